// ----- hdl/mcdqm_pkg.sv -----
// shared types and codes for the multi-class deque manager
`default_nettype none
package mcdqm_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TAKE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_ENTRY,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] entry_id;
    logic        urgent;
    logic [3:0]  count;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/multi_class_deque_manager_core.sv -----
// bank of bounded ring queues, urgent adds go to the head
// result formed in S_META, or in S_ENTRY for a take that returns an entry, held in
// S_HOLD while the output stalls; one item in flight, input stalls until it is loaded;
//   head/count memory is read then written back, plus the entry store read on a take
// reset: head/count valid bits cleared by reset, entry store is not cleared
// and needs no clearing pass, so items are accepted right after reset
`default_nettype none
module multi_class_deque_manager_core #(
  parameter int NUM_QUEUES  = 32,
  parameter int QUEUE_DEPTH = 8,
  parameter int ID_WIDTH    = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_opcode,
  input  wire  [4:0]  in_queue_index,
  input  wire  [15:0] in_entry_id,
  input  wire         in_urgent,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_entry_id,
  output logic        out_urgent,
  output logic [3:0]  out_queue_count
);

  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = PW + 1;
  localparam int NE  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW  = (NE > 1) ? $clog2(NE) : 1;
  localparam int DW  = ID_WIDTH + 1;

  mcdqm_pkg::state_t  state_r, state_nxt;
  logic [1:0]         op_r;
  logic [QIW-1:0]     qidx_r;
  logic [ID_WIDTH-1:0] id_r;
  logic               urg_r;
  logic               inrange_r;
  mcdqm_pkg::result_t res_r, res_nxt;
  mcdqm_pkg::result_t out_r;
  logic               out_vld_r;

  logic               accept;
  logic               in_range;
  logic               out_free;
  logic               finish;
  logic               load_hold;

  logic [PW-1:0]      m_head;
  logic [CW-1:0]      m_count;
  logic               m_wr_en;
  logic [PW-1:0]      m_wr_head;
  logic [CW-1:0]      m_wr_count;

  logic               e_rd_en;
  logic               e_wr_en;
  logic [AW-1:0]      e_addr;
  logic [DW-1:0]      e_rd_data;

  logic [SW-1:0]      tail_sum;
  logic [PW-1:0]      tail_slot;
  logic [PW-1:0]      head_dec;
  logic [PW-1:0]      head_inc;
  logic [PW-1:0]      slot;

  assign in_range = (32'(in_queue_index) < NUM_QUEUES);
  assign in_stall = (state_r != mcdqm_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  mcdqm_meta_ram #(
    .NUM_QUEUES(NUM_QUEUES),
    .PW(PW),
    .CW(CW)
  ) u_meta (
    .clk(clk),
    .rst_n(rst_n),
    .rd_en(accept && in_range),
    .rd_addr(QIW'(in_queue_index)),
    .wr_en(m_wr_en),
    .wr_addr(qidx_r),
    .wr_head(m_wr_head),
    .wr_count(m_wr_count),
    .rd_head(m_head),
    .rd_count(m_count)
  );

  mcdqm_entry_ram #(
    .DEPTH(NE),
    .DW(DW)
  ) u_entry (
    .clk(clk),
    .rd_en(e_rd_en),
    .rd_addr(e_addr),
    .wr_en(e_wr_en),
    .wr_addr(e_addr),
    .wr_data({urg_r, id_r}),
    .rd_data(e_rd_data)
  );

  // ring arithmetic, sums stay below twice the depth
  assign tail_sum  = SW'(m_head) + SW'(m_count);
  assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : PW'(tail_sum);
  assign head_dec  = (m_head == '0) ? PW'(QUEUE_DEPTH - 1) : PW'(m_head - 1'b1);
  assign head_inc  = (m_head == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(m_head + 1'b1);
  assign slot      = (op_r == mcdqm_pkg::OP_ADD) ? (urg_r ? head_dec : tail_slot) : m_head;
  assign e_addr    = AW'(AW'(qidx_r) * AW'(QUEUE_DEPTH) + AW'(slot));

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = '0;
    finish     = 1'b0;
    load_hold  = 1'b0;
    m_wr_en    = 1'b0;
    m_wr_head  = m_head;
    m_wr_count = m_count;
    e_rd_en    = 1'b0;
    e_wr_en    = 1'b0;
    case (state_r)
      mcdqm_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = mcdqm_pkg::S_META;
        end
      end
      mcdqm_pkg::S_META: begin
        finish = 1'b1;
        if (!inrange_r) begin
          if (op_r == mcdqm_pkg::OP_ADD) begin
            res_nxt.status = mcdqm_pkg::STAT_FULL;
          end else if (op_r == mcdqm_pkg::OP_TAKE) begin
            res_nxt.status = mcdqm_pkg::STAT_EMPTY;
          end
        end else begin
          case (op_r)
            mcdqm_pkg::OP_ADD: begin
              if (m_count == CW'(QUEUE_DEPTH)) begin
                res_nxt.status = mcdqm_pkg::STAT_FULL;
                res_nxt.count  = 4'(m_count);
              end else begin
                m_wr_en        = 1'b1;
                e_wr_en        = 1'b1;
                m_wr_head      = urg_r ? head_dec : m_head;
                m_wr_count     = CW'(m_count + 1'b1);
                res_nxt.count  = 4'(m_wr_count);
              end
            end
            mcdqm_pkg::OP_TAKE: begin
              if (m_count == '0) begin
                res_nxt.status = mcdqm_pkg::STAT_EMPTY;
              end else begin
                finish     = 1'b0;
                m_wr_en    = 1'b1;
                e_rd_en    = 1'b1;
                m_wr_head  = head_inc;
                m_wr_count = CW'(m_count - 1'b1);
                state_nxt  = mcdqm_pkg::S_ENTRY;
              end
            end
            default: begin
              res_nxt.count = 4'(m_count);
            end
          endcase
        end
      end
      mcdqm_pkg::S_ENTRY: begin
        finish           = 1'b1;
        res_nxt.entry_id = 16'(e_rd_data[ID_WIDTH-1:0]);
        res_nxt.urgent   = e_rd_data[ID_WIDTH];
        res_nxt.count    = 4'(CW'(m_count - 1'b1));
      end
      mcdqm_pkg::S_HOLD: begin
        if (out_free) begin
          load_hold = 1'b1;
          state_nxt = mcdqm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mcdqm_pkg::S_IDLE;
      end
    endcase
    if (finish) begin
      state_nxt = out_free ? mcdqm_pkg::S_IDLE : mcdqm_pkg::S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mcdqm_pkg::S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((finish && out_free) || load_hold) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_opcode;
      qidx_r    <= QIW'(in_queue_index);
      id_r      <= ID_WIDTH'(in_entry_id);
      urg_r     <= in_urgent;
      inrange_r <= in_range;
    end
    if (finish && !out_free) begin
      res_r <= res_nxt;
    end
    if (finish && out_free) begin
      out_r <= res_nxt;
    end else if (load_hold) begin
      out_r <= res_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_r.status;
  assign out_entry_id    = out_r.entry_id;
  assign out_urgent      = out_r.urgent;
  assign out_queue_count = out_r.count;

endmodule
`default_nettype wire

// ----- hdl/mcdqm_meta_ram.sv -----
// per-queue head pointer and count memory with reset-cleared valid bits
`default_nettype none
module mcdqm_meta_ram #(
  parameter int NUM_QUEUES = 32,
  parameter int PW = 3,
  parameter int CW = 4
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   rd_en,
  input  wire [(NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1)-1:0] rd_addr,
  input  wire                                   wr_en,
  input  wire [(NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1)-1:0] wr_addr,
  input  wire [PW-1:0]                          wr_head,
  input  wire [CW-1:0]                          wr_count,
  output logic [PW-1:0]                         rd_head,
  output logic [CW-1:0]                         rd_count
);

  logic [PW+CW-1:0]      mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld_r;
  logic [PW+CW-1:0]      rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_head, wr_count};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // an entry never written reads as head zero, count zero
  assign rd_head  = rd_vld_r ? rd_data_r[PW+CW-1:CW] : '0;
  assign rd_count = rd_vld_r ? rd_data_r[CW-1:0] : '0;

endmodule
`default_nettype wire

// ----- hdl/mcdqm_entry_ram.sv -----
// entry store: one slot of {urgent, id} per queue position
`default_nettype none
module mcdqm_entry_ram #(
  parameter int DEPTH = 256,
  parameter int DW = 17
) (
  input  wire                                    clk,
  input  wire                                    rd_en,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  wire                                    wr_en,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire [DW-1:0]                           wr_data,
  output logic [DW-1:0]                          rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- hdl/mcdqm_checker.sv -----
// port-level checks for the deque manager, bound to the top level
`default_nettype none
module mcdqm_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_status,
  input wire [15:0] out_entry_id,
  input wire        out_urgent,
  input wire [3:0]  out_queue_count
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_entry_id) && $stable(out_urgent) && $stable(out_queue_count))
    else $error("stalled result beat changed");

  // one item in flight: accept closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  // failed take carries no entry and an empty count
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mcdqm_pkg::STAT_EMPTY |->
      out_entry_id == 16'd0 && !out_urgent && out_queue_count == 4'd0)
    else $error("empty status with nonzero payload");

  // refused add returns no entry
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mcdqm_pkg::STAT_FULL |->
      out_entry_id == 16'd0 && !out_urgent)
    else $error("full status with entry payload");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_class_deque_manager_core mcdqm_checker u_mcdqm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_status(out_status),
  .out_entry_id(out_entry_id),
  .out_urgent(out_urgent),
  .out_queue_count(out_queue_count)
);
`default_nettype wire
